// ===== design/hbt_pkg.sv =====
// ----------------------------------------------------------------------------
// hbt_pkg
// Shared types and constants for the heartbeat timeout table.
// ----------------------------------------------------------------------------
package hbt_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int CNT_W = 8;
    localparam int IDX_W = 4;
    localparam logic [CNT_W-1:0] INIT_COUNT_RST = 8'd3;

    typedef enum logic [1:0] {
        OP_TICK      = 2'd0,
        OP_ADD       = 2'd1,
        OP_REMOVE    = 2'd2,
        OP_HEARTBEAT = 2'd3
    } op_t;

    // Controller to datapath
    typedef struct packed {
        logic op_en;   // apply a non-tick operation this cycle
        logic rd_en;   // read the counter at the walk pointer
        logic flush;   // emit the held report as the last of the run
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic stall;       // update stage waits on the output register
        logic s2_valid;    // update stage holds a slot
        logic hold_valid;  // one report is held back
    } sts_t;

endpackage

// ===== design/hbt_datapath.sv =====
// ----------------------------------------------------------------------------
// hbt_datapath
// Counter memory, slot flags, walk update stage, held report and output
// register.
// ----------------------------------------------------------------------------
module hbt_datapath #(
    parameter int SLOTS = hbt_pkg::SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hbt_pkg::cmd_t                     cmd,
    output hbt_pkg::sts_t                     sts,
    input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
    input  logic [1:0]                        opcode,
    input  logic [hbt_pkg::IDX_W-1:0]         slot_index,
    input  logic                              cfg_wr_en,
    input  logic [hbt_pkg::CNT_W-1:0]         cfg_wr_data,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [hbt_pkg::IDX_W-1:0]         m_slot,
    output logic                              m_last
);
    import hbt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [CNT_W-1:0]  mem [SLOTS];
    logic [CNT_W-1:0]  rd_data_reg;
    logic [CNT_W-1:0]  init_count_reg;
    logic [SLOTS-1:0]  active_reg, active_next;
    logic [SLOTS-1:0]  online_reg, online_next;
    logic              s2_valid_reg;
    logic [SLOT_W-1:0] s2_slot_reg;
    logic              hold_valid_reg;
    logic [SLOT_W-1:0] hold_slot_reg;
    logic              m_tvalid_reg;
    logic [IDX_W-1:0]  m_slot_reg;
    logic              m_last_reg;

    op_t               op;
    logic              in_range;
    logic [SLOT_W-1:0] op_addr;
    logic              op_reload;
    logic              s2_active;
    logic [CNT_W-1:0]  dec;
    logic              hit;
    logic              stall;
    logic              wb_en;
    logic              out_free;
    logic              push_mid;
    logic              push_last;

    assign op        = op_t'(opcode);
    assign in_range  = 32'(slot_index) < SLOTS;
    assign op_addr   = SLOT_W'(slot_index);
    assign op_reload = cmd.op_en && in_range && (op == OP_ADD || op == OP_HEARTBEAT);

    assign s2_active = active_reg[s2_slot_reg];
    assign dec       = (rd_data_reg != '0) ? rd_data_reg - CNT_W'(1) : '0;
    assign hit       = s2_valid_reg && s2_active && (dec == '0);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign stall     = hit && hold_valid_reg && !out_free;
    assign wb_en     = s2_valid_reg && s2_active && !stall;
    // a new expiry releases the previous one, which is then known not to be last
    assign push_mid  = hit && hold_valid_reg && out_free;
    assign push_last = cmd.flush && !s2_valid_reg && hold_valid_reg && out_free;

    assign sts.stall      = stall;
    assign sts.s2_valid   = s2_valid_reg;
    assign sts.hold_valid = hold_valid_reg;

    assign m_tvalid = m_tvalid_reg;
    assign m_slot   = m_slot_reg;
    assign m_last   = m_last_reg;

    always_ff @(posedge aclk) begin
        if (op_reload) begin
            mem[op_addr] <= init_count_reg;
        end else if (wb_en) begin
            mem[s2_slot_reg] <= dec;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        active_next = active_reg;
        online_next = online_reg;
        if (cmd.op_en && in_range) begin
            unique case (op)
                OP_ADD: begin
                    active_next[op_addr] = 1'b1;
                    online_next[op_addr] = 1'b1;
                end
                OP_HEARTBEAT: begin
                    online_next[op_addr] = 1'b1;
                end
                OP_REMOVE: begin
                    active_next[op_addr] = 1'b0;
                end
                OP_TICK: begin
                end
                default: begin
                end
            endcase
        end
        if (hit && !stall) begin
            online_next[s2_slot_reg] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            init_count_reg <= INIT_COUNT_RST;
            active_reg     <= '0;
            online_reg     <= '0;
            s2_valid_reg   <= 1'b0;
            hold_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                init_count_reg <= cfg_wr_data;
            end
            active_reg <= active_next;
            online_reg <= online_next;
            if (!stall) begin
                s2_valid_reg <= cmd.rd_en;
            end
            if (hit && !stall) begin
                hold_valid_reg <= 1'b1;
            end else if (push_last) begin
                hold_valid_reg <= 1'b0;
            end
            if (push_mid || push_last) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!stall) begin
            s2_slot_reg <= rd_addr;
        end
        if (hit && !stall) begin
            hold_slot_reg <= s2_slot_reg;
        end
        if (push_mid || push_last) begin
            m_slot_reg <= IDX_W'(hold_slot_reg);
            m_last_reg <= push_last;
        end
    end

    // a stalled update keeps its slot
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        stall |=> s2_valid_reg && $stable(s2_slot_reg) && $stable(rd_data_reg))
        else $error("update stage lost its slot during a stall");

    // only one report may leave per cycle
    a_one_push: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push_mid && push_last))
        else $error("two reports pushed in one cycle");

    // a report is never overwritten while the sink holds off
    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !m_tready) |-> !(push_mid || push_last))
        else $error("output register overwritten");

endmodule

// ===== design/hbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// hbt_ctrl
// Sequencer: takes operations, walks the slot table on a tick and drains the
// held report at the end of the walk.
// ----------------------------------------------------------------------------
module hbt_ctrl #(
    parameter int SLOTS = hbt_pkg::SLOTS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [1:0]                        opcode,
    input  hbt_pkg::sts_t                     sts,
    output hbt_pkg::cmd_t                     cmd,
    output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr
);
    import hbt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_WALK  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic              in_accept;
    logic              rd_en;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign rd_en     = (state_reg == ST_WALK) && !sts.stall;

    assign cmd.op_en = in_accept && (op_t'(opcode) != OP_TICK);
    assign cmd.rd_en = rd_en;
    assign cmd.flush = (state_reg == ST_DRAIN);
    assign rd_addr   = ptr_reg;

    always_comb begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                ptr_next = '0;
                if (in_accept && op_t'(opcode) == OP_TICK) begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                if (rd_en) begin
                    if (ptr_reg == LAST_SLOT) begin
                        state_next = ST_DRAIN;
                    end else begin
                        ptr_next = ptr_reg + SLOT_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                // leave once the last slot is updated and the held report, if any, is out
                if (!sts.s2_valid && !sts.hold_valid) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ptr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
        end
    end

    // no walk work is left over when a new operation may enter
    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !sts.s2_valid && !sts.hold_valid)
        else $error("operation accepted with walk still in flight");

    // the pointer starts every walk at slot zero
    a_walk_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && op_t'(opcode) == OP_TICK) |=> (state_reg == ST_WALK) && (ptr_reg == '0))
        else $error("walk did not start at slot zero");

    // a stall freezes the walk pointer
    a_stall_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && sts.stall) |=> $stable(ptr_reg))
        else $error("walk pointer moved during a stall");

endmodule

// ===== design/heartbeat_timeout_table_top.sv =====
// ----------------------------------------------------------------------------
// heartbeat_timeout_table_top
// Table of watched slots with per-slot beat counters and expiry reports.
// ----------------------------------------------------------------------------
// Add, remove and heartbeat are applied as they are accepted and the block
// stays ready for further operations. A tick walks the slot table one slot
// per cycle, while the update stage does not stall, through the single read
// port of the counter memory, with an update stage behind it. A tick holds
// off the input until the walk is done and the held report has left, also
// while the sink holds m_tready low. One expired slot is held back during
// the walk so that its successor, or the end of the walk, decides m_tlast;
// reports leave in ascending slot order, at most one per cycle. The counter
// memory is not cleared after reset: every slot is loaded by its add.
module heartbeat_timeout_table_top #(
    parameter int SLOTS = hbt_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [7:0]                  s_tdata,   // [1:0] opcode, [5:2] slot_index
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [7:0]                  m_tdata,   // [3:0] expired_slot
    output logic                        m_tlast,   // last_of_run
    input  logic                        cfg_wr_en,
    input  logic [hbt_pkg::CNT_W-1:0]   cfg_wr_data // initial_count
);
    import hbt_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    cmd_t              cmd;
    sts_t              sts;
    logic [SLOT_W-1:0] rd_addr;
    logic [IDX_W-1:0]  m_slot;

    hbt_ctrl #(
        .SLOTS (SLOTS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tdata[1:0]),
        .sts      (sts),
        .cmd      (cmd),
        .rd_addr  (rd_addr)
    );

    hbt_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .rd_addr     (rd_addr),
        .opcode      (s_tdata[1:0]),
        .slot_index  (s_tdata[5:2]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_slot      (m_slot),
        .m_last      (m_tlast)
    );

    assign m_tdata = {4'b0000, m_slot};

endmodule
